/* rtl/cleh_pkg.sv */
// Package with the shared types and codes of the console line editor.
package cleh_pkg;

  localparam int LineChars   = 64;
  localparam int HistEntries = 16;

  localparam logic [2:0] ActEcho    = 3'd0;
  localparam logic [2:0] ActErase   = 3'd1;
  localparam logic [2:0] ActCmdChar = 3'd2;
  localparam logic [2:0] ActCmdEnd  = 3'd3;
  localparam logic [2:0] ActRedraw  = 3'd4;
  localparam logic [2:0] ActCtrlC   = 3'd5;
  localparam logic [2:0] ActTooLong = 3'd6;
  localparam logic [2:0] ActLost    = 3'd7;

  localparam logic [7:0] ChEtx = 8'd3;
  localparam logic [7:0] ChBs  = 8'd8;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChSo  = 8'd14;
  localparam logic [7:0] ChDle = 8'd16;
  localparam logic [7:0] ChNak = 8'd21;
  localparam logic [7:0] ChEsc = 8'd27;
  localparam logic [7:0] ChDel = 8'd127;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChLbr = 8'h5B;
  localparam logic [7:0] ChO   = 8'h4F;
  localparam logic [7:0] ChA   = 8'h41;
  localparam logic [7:0] ChB   = 8'h42;

  localparam logic [1:0] EscIdle = 2'd0;
  localparam logic [1:0] EscSeen = 2'd1;
  localparam logic [1:0] EscSeq  = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] char_value;
    logic       discarding;
    logic       last;
  } res_t;

endpackage

/* rtl/cleh_out_reg.sv */
// Output register stage that holds one result until the consumer takes it.
module cleh_out_reg
  import cleh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign full_o  = valid_q && !ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTH
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !(valid_q && !ready_i)) else $error("push into a full output stage");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i && !push_i |=> valid_q && $stable(res_q))
    else $error("output lost while stalled");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && res_i.action != ActEcho && res_i.action != ActErase &&
    res_i.action != ActCmdChar |-> res_i.char_value == 7'd0)
    else $error("char_value not zero for a prompt action");
`endif

endmodule

/* rtl/console_line_editor_history_unit.sv */
// Console line editor with history: one byte a request, edits kept in block memories.
// Each request is handled by a sequencer that reads one memory word a cycle unless the
// output stalls. A plain character is taken into a pending result register, which enters
// the output stage once that stage has room. A history step saves the typed line when
// browsing starts, copies the chosen line into the edit line and redraws it. Enter scans
// the line for a non-blank character, compares a non-blank line against the newest
// history entry, writes a new entry if it differs, and emits the command run. Memories
// are the edit line, the saved line and the history store; none is cleared after reset.
module console_line_editor_history_unit
  import cleh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  input  logic        s_axis_tuser,  // rx_lost
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // action[2:0], char_value[9:3], zero fill
  output logic        m_axis_tuser,  // discarding
  output logic        m_axis_tlast   // last
);

  localparam int LW = $clog2(LineChars);
  localparam int HW = (HistEntries > 1) ? $clog2(HistEntries) : 1;
  localparam int FW = $clog2(HistEntries + 1);
  localparam logic [LW:0] LMax = (LW + 1)'(LineChars - 1);
  localparam logic [FW-1:0] HEnt = FW'(HistEntries);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT1, S_BLANK, S_CMP, S_CMPW, S_HWR, S_CMDRUN, S_CMDEND,
    S_SAVE, S_LOAD, S_REDRAW, S_ECHOS
  } state_e;

  // memories
  logic [6:0] line_mem [LineChars];
  logic [6:0] save_mem [LineChars];
  logic [6:0] hist_mem [HistEntries * LineChars];
  logic [LW-1:0] hlen_mem [HistEntries];

  state_e state_q;
  logic [LW-1:0] len_q, slen_q, cnt_q, tlen_q;
  logic [1:0] esc_q;
  logic swlf_q, disc_q;
  logic [HW-1:0] wpos_q, ridx_q;
  logic [FW-1:0] fill_q, brw_q;
  logic src_save_q, nonblank_q, eq_q;

  logic [6:0] line_rd, save_rd, hist_rd;
  logic [LW-1:0] hlen_rd;

  logic line_we, save_we, hist_we;
  logic [LW-1:0] line_wa, line_ra, save_wa, save_ra, hist_off;
  logic [6:0] line_wd, save_wd, hist_wd;
  logic [HW-1:0] hist_row, hlen_ra;
  logic hlen_we;

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    line_rd <= line_mem[line_ra];
    if (save_we) save_mem[save_wa] <= save_wd;
    save_rd <= save_mem[save_ra];
    if (hist_we) hist_mem[{hist_row, hist_off}] <= hist_wd;
    hist_rd <= hist_mem[{hist_row, hist_off}];
    if (hlen_we) hlen_mem[wpos_q] <= len_q;
    hlen_rd <= hlen_mem[hlen_ra];
  end

  logic push, full;
  res_t res;
  res_t ores;

  cleh_out_reg u_out (
    .clk_i, .rst_ni, .push_i(push), .res_i(res), .full_o(full),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(ores)
  );

  // Cycle-local control into the next state.
  state_e state_d;
  logic [LW-1:0] len_d, slen_d, cnt_d, tlen_d;
  logic [1:0] esc_d;
  logic swlf_d, disc_d, src_save_d, nonblank_d, eq_d;
  logic [HW-1:0] wpos_d, ridx_d;
  logic [FW-1:0] fill_d, brw_d;
  logic emit1_q, emit1_d;
  res_t r1_q, r1_d;

  assign m_axis_tdata = {6'd0, ores.char_value, ores.action};
  assign m_axis_tuser = ores.discarding;
  assign m_axis_tlast = ores.last;
  assign s_axis_tready = (state_q == S_IDLE) && !full && !emit1_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  logic [7:0] c, cc;
  assign c = s_axis_tdata;
  assign cc = (c == ChTab) ? ChSp : c;

  logic [HW-1:0] newest;
  assign newest = wpos_q - HW'(1);

  function automatic res_t mk(logic [2:0] a, logic [6:0] ch, logic d, logic l);
    res_t r;
    r.action = a; r.char_value = ch; r.discarding = d; r.last = l;
    return r;
  endfunction

  // Request a history walk and its direction.
  logic walk_ok;
  logic walk_back;
  always_comb begin
    state_d = state_q; len_d = len_q; slen_d = slen_q; cnt_d = cnt_q; tlen_d = tlen_q;
    esc_d = esc_q; swlf_d = swlf_q; disc_d = disc_q; wpos_d = wpos_q; ridx_d = ridx_q;
    fill_d = fill_q; brw_d = brw_q; src_save_d = src_save_q; nonblank_d = nonblank_q;
    eq_d = eq_q; emit1_d = 1'b0; r1_d = r1_q;
    push = 1'b0; res = mk(ActEcho, 7'd0, 1'b0, 1'b0);
    line_we = 1'b0; line_wa = len_q; line_wd = cc[6:0]; line_ra = cnt_q;
    save_we = 1'b0; save_wa = cnt_q; save_wd = line_rd; save_ra = cnt_q;
    hist_we = 1'b0; hist_row = ridx_q; hist_off = cnt_q; hist_wd = line_rd;
    hlen_we = 1'b0; hlen_ra = ridx_q;
    walk_ok = 1'b0; walk_back = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (emit1_q && !full) begin
          push = 1'b1; res = r1_q;
        end else if (acc) begin
          if (s_axis_tuser) begin
            len_d = '0; esc_d = EscIdle; brw_d = '0; slen_d = '0; swlf_d = 1'b0;
            disc_d = 1'b1; emit1_d = 1'b1; r1_d = mk(ActLost, 7'd0, 1'b1, 1'b1);
          end else if (c == ChLf && swlf_q) begin
            swlf_d = 1'b0;
          end else if (c == ChEtx) begin
            len_d = '0; esc_d = EscIdle; brw_d = '0; slen_d = '0; swlf_d = 1'b0;
            disc_d = 1'b0; emit1_d = 1'b1; r1_d = mk(ActCtrlC, 7'd0, 1'b0, 1'b1);
          end else if (c == ChCr || c == ChLf) begin
            swlf_d = (c == ChCr);
            if (disc_q) begin
              emit1_d = 1'b1; r1_d = mk(ActRedraw, 7'd0, 1'b0, 1'b1);
              len_d = '0; esc_d = EscIdle; brw_d = '0; slen_d = '0; disc_d = 1'b0;
            end else begin
              cnt_d = '0; nonblank_d = 1'b0; ridx_d = newest; state_d = S_BLANK;
            end
          end else if (disc_q) begin
            swlf_d = 1'b0;
          end else if (c == ChNak) begin
            swlf_d = 1'b0; len_d = '0; esc_d = EscIdle; brw_d = '0; slen_d = '0;
            emit1_d = 1'b1; r1_d = mk(ActRedraw, 7'd0, 1'b0, 1'b1);
          end else if (c == ChDle || c == ChSo) begin
            swlf_d = 1'b0; esc_d = EscIdle; walk_ok = 1'b1; walk_back = (c == ChDle);
          end else if (c == ChEsc) begin
            swlf_d = 1'b0; esc_d = EscSeen;
          end else if (esc_q == EscSeen) begin
            swlf_d = 1'b0; esc_d = (c == ChLbr || c == ChO) ? EscSeq : EscIdle;
          end else if (esc_q == EscSeq) begin
            swlf_d = 1'b0;
            if (c >= 8'h40 && c <= 8'h7E) begin
              esc_d = EscIdle;
              if (c == ChA || c == ChB) begin
                walk_ok = 1'b1; walk_back = (c == ChA);
              end
            end else if (c < 8'h20 || c > 8'h3F) begin
              esc_d = EscIdle;
            end
          end else begin
            swlf_d = 1'b0; esc_d = EscIdle;
            if (c == ChBs || c == ChDel) begin
              if (len_q != '0) begin
                len_d = len_q - LW'(1);
                emit1_d = 1'b1; r1_d = mk(ActErase, 7'd0, 1'b0, 1'b1);
              end
            end else if (cc >= 8'h20 && cc <= 8'h7E) begin
              if ({1'b0, len_q} + (LW + 1)'(1) >= LMax + (LW + 1)'(1)) begin
                len_d = '0; brw_d = '0; slen_d = '0; disc_d = 1'b1;
                emit1_d = 1'b1; r1_d = mk(ActTooLong, 7'd0, 1'b1, 1'b1);
              end else begin
                line_we = 1'b1; len_d = len_q + LW'(1);
                emit1_d = 1'b1; r1_d = mk(ActEcho, cc[6:0], 1'b0, 1'b1);
              end
            end
          end
          if (walk_ok) begin
            if (walk_back) begin
              if (brw_q < fill_q) begin
                brw_d = brw_q + FW'(1);
                ridx_d = wpos_q - HW'(brw_q + FW'(1));
                src_save_d = 1'b0; cnt_d = '0;
                state_d = (brw_q == '0) ? S_SAVE : S_LOAD;
                if (brw_q == '0) slen_d = len_q;
              end
            end else if (brw_q != '0) begin
              brw_d = brw_q - FW'(1);
              ridx_d = wpos_q - HW'(brw_q - FW'(1));
              src_save_d = (brw_q == FW'(1)); cnt_d = '0; state_d = S_LOAD;
            end
          end
        end
      end
      // copy edit line into saved line; line read data is registered, so writes trail the read address
      S_SAVE: begin
        line_ra = cnt_q;
        save_wa = cnt_q - LW'(1); save_we = (cnt_q != '0);
        if (cnt_q == slen_q) begin
          cnt_d = '0; state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      // copy history row or saved line into edit line
      S_LOAD: begin
        save_ra = cnt_q;
        hist_row = ridx_q; hist_off = cnt_q; hlen_ra = ridx_q;
        if (cnt_q == '0) begin
          tlen_d = src_save_q ? slen_q : tlen_q;
        end else begin
          if (cnt_q == LW'(1) && !src_save_q) tlen_d = hlen_rd;
          line_we = 1'b1; line_wa = cnt_q - LW'(1);
          line_wd = src_save_q ? save_rd : hist_rd;
        end
        if (cnt_q != '0 && (cnt_q - LW'(1)) >= ((cnt_q == LW'(1) && !src_save_q) ?
            hlen_rd : tlen_q)) begin
          line_we = 1'b0;
          len_d = (cnt_q == LW'(1) && !src_save_q) ? hlen_rd : tlen_q;
          cnt_d = '0; state_d = S_REDRAW;
        end else if (cnt_q == LMax[LW-1:0]) begin
          len_d = tlen_d; cnt_d = '0; state_d = S_REDRAW;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      S_REDRAW: begin
        if (!full) begin
          push = 1'b1; res = mk(ActRedraw, 7'd0, disc_q, len_q == '0);
          cnt_d = '0; state_d = (len_q == '0) ? S_IDLE : S_ECHOS;
        end
        line_ra = '0;
      end
      S_ECHOS: begin
        if (!full) begin
          push = 1'b1; res = mk(ActEcho, line_rd, 1'b0, cnt_q == len_q - LW'(1));
          cnt_d = cnt_q + LW'(1);
          line_ra = cnt_q + LW'(1);
          if (cnt_q == len_q - LW'(1)) state_d = S_IDLE;
        end else begin
          line_ra = cnt_q;
        end
      end
      // scan for a non-blank character
      S_BLANK: begin
        line_ra = cnt_q;
        if (cnt_q != '0 && line_rd != 7'h20) nonblank_d = 1'b1;
        if (cnt_q == len_q) begin
          cnt_d = '0; eq_d = 1'b1; hlen_ra = newest;
          state_d = (nonblank_d && fill_q != '0) ? S_CMP : S_CMPW;
          if (!nonblank_d) eq_d = 1'b1;
          else if (fill_q == '0) eq_d = 1'b0;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      // compare with the newest entry
      S_CMP: begin
        hist_row = newest; hist_off = cnt_q; line_ra = cnt_q; hlen_ra = newest;
        if (cnt_q == LW'(1) && hlen_rd != len_q) eq_d = 1'b0;
        if (cnt_q != '0 && hist_rd != line_rd) eq_d = 1'b0;
        if (cnt_q == len_q || (cnt_q == LW'(1) && hlen_rd != len_q)) begin
          cnt_d = '0; state_d = S_CMPW;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      S_CMPW: begin
        cnt_d = '0;
        state_d = (nonblank_q && !eq_q) ? S_HWR : S_CMDRUN;
        line_ra = '0;
      end
      S_HWR: begin
        line_ra = cnt_q; hist_row = wpos_q; hist_off = cnt_q - LW'(1);
        hist_we = (cnt_q != '0);
        if (cnt_q == len_q) begin
          hlen_we = 1'b1; wpos_d = wpos_q + HW'(1);
          if (wpos_q == HW'(HistEntries - 1)) wpos_d = '0;
          if (fill_q < HEnt) fill_d = fill_q + FW'(1);
          cnt_d = '0; line_ra = '0; state_d = S_CMDRUN;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      S_CMDRUN: begin
        line_ra = cnt_q;
        if (cnt_q == len_q) begin
          state_d = S_CMDEND;
        end else if (!full) begin
          push = 1'b1; res = mk(ActCmdChar, line_rd, 1'b0, 1'b0);
          cnt_d = cnt_q + LW'(1); line_ra = cnt_q + LW'(1);
        end
      end
      S_CMDEND: begin
        if (!full) begin
          push = 1'b1; res = mk(ActCmdEnd, 7'd0, 1'b0, 1'b1);
          len_d = '0; esc_d = EscIdle; brw_d = '0; slen_d = '0; disc_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; len_q <= '0; slen_q <= '0; cnt_q <= '0; tlen_q <= '0;
      esc_q <= EscIdle; swlf_q <= 1'b0; disc_q <= 1'b0; wpos_q <= '0; ridx_q <= '0;
      fill_q <= '0; brw_q <= '0; src_save_q <= 1'b0; nonblank_q <= 1'b0; eq_q <= 1'b0;
      emit1_q <= 1'b0; r1_q <= '0;
    end else begin
      state_q <= state_d; len_q <= len_d; slen_q <= slen_d; cnt_q <= cnt_d;
      tlen_q <= tlen_d; esc_q <= esc_d; swlf_q <= swlf_d; disc_q <= disc_d;
      wpos_q <= wpos_d; ridx_q <= ridx_d; fill_q <= fill_d; brw_q <= brw_d;
      src_save_q <= src_save_d; nonblank_q <= nonblank_d; eq_q <= eq_d;
      emit1_q <= emit1_d || (emit1_q && full); r1_q <= r1_d;
    end
  end

`ifndef SYNTH
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, len_q} < LMax + (LW + 1)'(1)) else $error("line length out of range");
  a_brw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brw_q <= fill_q) else $error("browse offset past ring fill");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HEnt) else $error("ring fill too large");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready) else $error("request taken while busy");
`endif

endmodule
